// ===== rtl/core/dtp_pkg.sv =====
// Package for the two-bit DNA packer: transaction payload types, queue entry type
// and the character and result-kind codes shared by the front, queue and back modules.
// No dependencies.
package dtp_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_C_UP = 8'h43;
  localparam logic [7:0] CH_G_UP = 8'h47;
  localparam logic [7:0] CH_T_UP = 8'h54;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_C_LO = 8'h63;
  localparam logic [7:0] CH_G_LO = 8'h67;
  localparam logic [7:0] CH_T_LO = 8'h74;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  typedef struct packed {
    logic [7:0] base_char;
    logic       end_of_seq;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  packed_byte;
    logic [31:0] run_start;
    logic [31:0] run_end;
    logic        final_result;
  } out_item_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  res0;
    out_item_t  res1;
  } entry_t;

endpackage

// ===== rtl/core/dna_twobit_packer.sv =====
// Two-bit DNA packer top level: front end, entry queue, back end.
// A taken character's results go into the entry queue, then into the output register.
// The front end takes one character per cycle while the queue has room; a character
// with two results holds the back end for both, absorbed by the four-entry queue.
// Reset (rst, synchronous): clears position, pending codes, open run, queue and output.
// Depends on dtp_pkg, dtp_front, dtp_queue, dtp_back.
module dna_twobit_packer #(
  parameter int POS_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dtp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dtp_pkg::out_item_t out_data
);

  logic            push_valid;
  logic            push_ready;
  dtp_pkg::entry_t push_data;
  logic            pop_valid;
  logic            pop_ready;
  dtp_pkg::entry_t pop_data;

  dtp_front #(
    .POS_BITS(POS_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  dtp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  dtp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (pop_valid),
    .head_ready (pop_ready),
    .head       (pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/core/dtp_front.sv =====
// Front end of the two-bit DNA packer: classifies each character, tracks position,
// pending codes and the open run, and builds one queue entry of up to two results.
// Depends on dtp_pkg.
module dtp_front #(
  parameter int POS_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dtp_pkg::in_item_t in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output dtp_pkg::entry_t   push_data
);

  logic [POS_BITS-1:0] position;
  logic [POS_BITS-1:0] position_next;
  logic [POS_BITS-1:0] current_run_start;
  logic [POS_BITS-1:0] current_run_start_next;
  logic [5:0]          pending_bits;
  logic [5:0]          pending_bits_next;
  logic [1:0]          pending_count;
  logic [1:0]          pending_count_next;

  logic                is_base;
  logic [1:0]          code;
  logic                accept;
  logic                va, vb, vc;
  dtp_pkg::out_item_t  ra, rb, rc, r0, r1;
  logic [1:0]          n;
  logic [7:0]          flush_byte;

  always_comb begin
    is_base = 1'b1;
    code    = dtp_pkg::CODE_A;
    unique case (in_data.base_char) inside
      dtp_pkg::CH_A_UP, dtp_pkg::CH_A_LO: code = dtp_pkg::CODE_A;
      dtp_pkg::CH_C_UP, dtp_pkg::CH_C_LO: code = dtp_pkg::CODE_C;
      dtp_pkg::CH_G_UP, dtp_pkg::CH_G_LO: code = dtp_pkg::CODE_G;
      dtp_pkg::CH_T_UP, dtp_pkg::CH_T_LO: code = dtp_pkg::CODE_T;
      default: is_base = 1'b0;
    endcase
  end

  always_comb begin
    position_next          = (position == '1) ? position : position + POS_BITS'(1);
    current_run_start_next = current_run_start;
    pending_bits_next      = pending_bits;
    pending_count_next     = pending_count;
    va = 1'b0;
    ra = '0;
    if (!is_base) begin
      va = position > current_run_start;
      ra.kind      = dtp_pkg::KIND_RUN;
      ra.run_start = 32'(current_run_start);
      ra.run_end   = 32'(position);
      current_run_start_next = position_next;
    end else if (pending_count == 2'd3) begin
      va = 1'b1;
      ra.kind        = dtp_pkg::KIND_BYTE;
      ra.packed_byte = {pending_bits, code};
      pending_bits_next  = '0;
      pending_count_next = '0;
    end else begin
      pending_bits_next  = {pending_bits[3:0], code};
      pending_count_next = pending_count + 2'd1;
    end

    case (pending_count_next)
      2'd1:    flush_byte = {pending_bits_next[1:0], 6'b0};
      2'd2:    flush_byte = {pending_bits_next[3:0], 4'b0};
      2'd3:    flush_byte = {pending_bits_next, 2'b0};
      default: flush_byte = 8'h00;
    endcase

    vb = in_data.end_of_seq && (pending_count_next != 2'd0);
    rb = '0;
    rb.kind        = dtp_pkg::KIND_BYTE;
    rb.packed_byte = flush_byte;

    vc = in_data.end_of_seq && (position_next > current_run_start_next);
    rc = '0;
    rc.kind      = dtp_pkg::KIND_RUN;
    rc.run_start = 32'(current_run_start_next);
    rc.run_end   = 32'(position_next);

    r0 = va ? ra : (vb ? rb : rc);
    r1 = (va && vb) ? rb : rc;
    n  = 2'(va) + 2'(vb) + 2'(vc);
    if (in_data.end_of_seq) begin
      if (n == 2'd2) begin
        r1.final_result = 1'b1;
      end else begin
        r0.final_result = 1'b1;
      end
    end
  end

  assign accept     = in_valid && push_ready;
  assign in_ready   = push_ready;
  assign push_valid = in_valid && (n != 2'd0);
  assign push_data  = '{count: n, res0: r0, res1: r1};

  always_ff @(posedge clk) begin
    if (rst) begin
      position          <= '0;
      current_run_start <= '0;
      pending_bits      <= '0;
      pending_count     <= '0;
    end else if (accept) begin
      if (in_data.end_of_seq) begin
        position          <= '0;
        current_run_start <= '0;
        pending_bits      <= '0;
        pending_count     <= '0;
      end else begin
        position          <= position_next;
        current_run_start <= current_run_start_next;
        pending_bits      <= pending_bits_next;
        pending_count     <= pending_count_next;
      end
    end
  end

endmodule

// ===== rtl/core/dtp_queue.sv =====
// Short entry queue between the front and back ends of the two-bit DNA packer.
// Depends on dtp_pkg.
module dtp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  dtp_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output dtp_pkg::entry_t pop_data
);

  dtp_pkg::entry_t                 mem [dtp_pkg::QUEUE_DEPTH];
  logic [dtp_pkg::QPTR_BITS-1:0]   wr_ptr;
  logic [dtp_pkg::QPTR_BITS-1:0]   rd_ptr;
  logic [dtp_pkg::QCNT_BITS-1:0]   count;
  logic                            push;
  logic                            pop;

  assign push_ready = count != dtp_pkg::QCNT_BITS'(dtp_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + dtp_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + dtp_pkg::QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + dtp_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - dtp_pkg::QCNT_BITS'(1);
      end
    end
  end

endmodule

// ===== rtl/core/dtp_back.sv =====
// Back end of the two-bit DNA packer: walks the results of each queue entry in
// order into the output register. Depends on dtp_pkg.
module dtp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  output logic               head_ready,
  input  dtp_pkg::entry_t    head,
  output logic               out_valid,
  input  logic               out_ready,
  output dtp_pkg::out_item_t out_data
);

  logic sel;
  logic load;
  logic last;

  assign load       = head_valid && (!out_valid || out_ready);
  assign last       = sel || (head.count == 2'd1);
  assign head_ready = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      sel       <= !last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= sel ? head.res1 : head.res0;
    end
  end

endmodule

// ===== dv/dna_twobit_packer_tb.sv =====
// Self-checking testbench for dna_twobit_packer: drives sequence characters, predicts packed
// bytes and run records, and compares every output transaction in order.
// Depends on dtp_pkg and the dna_twobit_packer RTL.
module dna_twobit_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_W       = 16;
  localparam int STUCK_LIMIT = 4000;
  localparam logic [POS_W-1:0] POS_TOP = '1;
  localparam logic [7:0] CH_GAP = 8'h4E;
  localparam logic [7:0] BASES [8] = '{dtp_pkg::CH_A_UP, dtp_pkg::CH_C_UP,
                                       dtp_pkg::CH_G_UP, dtp_pkg::CH_T_UP,
                                       dtp_pkg::CH_A_LO, dtp_pkg::CH_C_LO,
                                       dtp_pkg::CH_G_LO, dtp_pkg::CH_T_LO};

  typedef struct {
    dtp_pkg::in_item_t item;
    bit                drain;
  } char_slot_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  dtp_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  dtp_pkg::out_item_t out_data;

  char_slot_t         char_q [$];
  dtp_pkg::out_item_t pending_results [$];

  logic [POS_W-1:0] cur_pos = '0;
  logic [POS_W-1:0] open_start = '0;
  logic [5:0]       held_codes = '0;
  logic [1:0]       held_cnt = '0;

  int results_due = 0;
  int results_got = 0;
  int chars_taken = 0;
  int bytes_seen = 0;
  int runs_seen = 0;
  int seqs_queued = 0;
  int errors = 0;
  int hold_left = 0;
  bit held_once = 0;
  int stuck = 0;
  dtp_pkg::out_item_t want;

  dna_twobit_packer #(.POS_BITS(POS_W)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  function automatic logic [POS_W-1:0] bump(logic [POS_W-1:0] p);
    return (p == POS_TOP) ? p : p + 1'b1;
  endfunction

  function automatic dtp_pkg::out_item_t byte_result(logic [7:0] b);
    dtp_pkg::out_item_t r;
    r = '0;
    r.kind = dtp_pkg::KIND_BYTE;
    r.packed_byte = b;
    return r;
  endfunction

  function automatic dtp_pkg::out_item_t run_result(logic [POS_W-1:0] s,
                                                    logic [POS_W-1:0] e);
    dtp_pkg::out_item_t r;
    r = '0;
    r.kind = dtp_pkg::KIND_RUN;
    r.run_start = 32'(s);
    r.run_end = 32'(e);
    return r;
  endfunction

  task automatic pack_char(dtp_pkg::in_item_t it);
    dtp_pkg::out_item_t res [$];
    logic [POS_W-1:0]   here;
    logic [POS_W-1:0]   nxt;
    logic [1:0]         code;
    logic [7:0]         flushed;
    bit                 is_base;
    int                 sh;
    here = cur_pos;
    nxt = bump(here);
    is_base = 1'b1;
    code = dtp_pkg::CODE_A;
    case (it.base_char)
      dtp_pkg::CH_A_UP, dtp_pkg::CH_A_LO: code = dtp_pkg::CODE_A;
      dtp_pkg::CH_C_UP, dtp_pkg::CH_C_LO: code = dtp_pkg::CODE_C;
      dtp_pkg::CH_G_UP, dtp_pkg::CH_G_LO: code = dtp_pkg::CODE_G;
      dtp_pkg::CH_T_UP, dtp_pkg::CH_T_LO: code = dtp_pkg::CODE_T;
      default: is_base = 1'b0;
    endcase
    if (!is_base) begin
      if (here > open_start) res.push_back(run_result(open_start, here));
      open_start = nxt;
    end else if (held_cnt == 2'd3) begin
      res.push_back(byte_result({held_codes, code}));
      held_codes = '0;
      held_cnt = '0;
    end else begin
      held_codes = {held_codes[3:0], code};
      held_cnt = held_cnt + 2'd1;
    end
    cur_pos = nxt;
    if (it.end_of_seq) begin
      if (held_cnt != 2'd0) begin
        sh = 8 - 2 * int'(held_cnt);
        flushed = 8'({2'b00, held_codes}) << sh;
        res.push_back(byte_result(flushed));
      end
      if (cur_pos > open_start) res.push_back(run_result(open_start, cur_pos));
      if (res.size() > 0) res[res.size()-1].final_result = 1'b1;
      cur_pos = '0;
      open_start = '0;
      held_codes = '0;
      held_cnt = '0;
    end
    foreach (res[i]) pending_results.push_back(res[i]);
    results_due += res.size();
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      errors++;
    end
  endtask

  function void add_char(logic [7:0] c, bit eos, bit drain);
    char_slot_t s;
    s.item.base_char = c;
    s.item.end_of_seq = eos;
    s.drain = drain;
    char_q.push_back(s);
    if (eos) seqs_queued++;
  endfunction

  function void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1, 1'b0);
  endfunction

  function automatic logic [7:0] pick_base();
    return BASES[$urandom_range(7)];
  endfunction

  function automatic logic [7:0] rand_char();
    return ($urandom_range(99) < 85) ? pick_base() : 8'($urandom_range(255));
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pack_char(in_data);
        chars_taken++;
      end
      if (!in_valid || in_ready) begin
        if (char_q.size() != 0 && !(char_q[0].drain && results_due != results_got) &&
            ((chars_taken >= 200 && chars_taken < 330) || $urandom_range(99) >= 18)) begin
          in_valid <= 1'b1;
          in_data <= char_q[0].item;
          char_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0b byte 0x%0h run [%0d, %0d) final %0b",
                 out_data.kind, out_data.packed_byte, out_data.run_start,
                 out_data.run_end, out_data.final_result);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_data.kind));
          check_field("packed_byte", 32'(want.packed_byte), 32'(out_data.packed_byte));
          check_field("run_start", want.run_start, out_data.run_start);
          check_field("run_end", want.run_end, out_data.run_end);
          check_field("final_result", 32'(want.final_result), 32'(out_data.final_result));
        end
        if (out_data.kind == dtp_pkg::KIND_RUN) runs_seen++;
        else bytes_seen++;
        results_got <= results_got + 1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held_once && results_got == 120) begin
        held_once = 1'b1;
        hold_left = 80;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (results_got >= 300 && results_got < 420) || $urandom_range(99) >= 18;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck <= 0;
    end else if (stuck == STUCK_LIMIT) begin
      $display("dna_twobit_packer_tb NOT OK");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    int n_rand;
    int len;
    bit noise;
    bit first_seq;
    logic [7:0] c;

    add_text("A");
    add_text("N");
    add_text("cGtA");
    add_char(8'h00, 1'b0, 1'b0);
    add_text("TG");
    add_char(8'hFF, 1'b1, 1'b0);
    add_char(dtp_pkg::CH_T_LO, 1'b0, 1'b0);
    add_char(CH_GAP, 1'b0, 1'b0);
    add_char(8'h80, 1'b1, 1'b0);
    add_text("gaTtc");

    n_rand = 0;
    first_seq = 1'b1;
    while (n_rand < 500) begin
      noise = $urandom_range(99) < 15;
      len = noise ? $urandom_range(1, 3) : $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
        c = noise ? 8'($urandom_range(255)) : rand_char();
        add_char(c, i == len - 1, first_seq && i == 0);
      end
      first_seq = 1'b0;
      n_rand += len;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (char_q.size() != 0 || in_valid) @(posedge clk);
    while (results_got != results_due) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d characters in %0d sequences: %0d packed bytes, %0d run records,",
             chars_taken, seqs_queued, bytes_seen, runs_seen);
    $display("with run breaks, noise characters, final flushes and a long output stall");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("dna_twobit_packer_tb OK");
    end else begin
      $display("dna_twobit_packer_tb NOT OK");
    end
    $finish;
  end

endmodule
